// ----- rtl/sbbt_pkg.sv -----
// shared types and constants of the band beat tracker
`default_nettype none
package sbbt_pkg;
  localparam int MaxBins = 256;
  localparam int CntW = 9;
  localparam int SumW = 24;
  localparam logic [15:0] Full = 16'hFFFF;
  localparam logic [15:0] KPeakDecay = 16'd19661;
  localparam logic [15:0] KFloor = 16'd66;
  localparam logic [15:0] KPeakReset = 16'd655;
  localparam logic [15:0] WBass = 16'd32768;
  localparam logic [15:0] WMid = 16'd19661;
  localparam logic [15:0] WTreb = 16'd13107;
  localparam logic [1:0] RegBassEnd = 2'd0;
  localparam logic [1:0] RegMidEnd = 2'd1;
  localparam logic [1:0] RegTrebEnd = 2'd2;
  localparam logic [1:0] RegThresh = 2'd3;

  typedef enum logic [1:0] {
    OP_BIN = 2'd0, OP_DECAY = 2'd1, OP_CLEAR = 2'd2, OP_NONE = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [15:0] magnitude;
    logic last_bin;
    logic [15:0] frame_time;
  } in_item_t;

  typedef struct packed {
    logic [15:0] bass_level;
    logic [15:0] mid_level;
    logic [15:0] treble_level;
    logic [15:0] beat_pulse;
    logic [15:0] energy_level;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_FRAME = 2'd0, CMD_DECAY = 2'd1, CMD_CLEAR = 2'd2
  } cmd_kind_t;

  // frame, decay or clear command passed from the accumulator front to the frame engine
  typedef struct packed {
    cmd_kind_t kind;
    logic [15:0] ft;
    logic [SumW-1:0] sum_b;
    logic [SumW-1:0] sum_m;
    logic [SumW-1:0] sum_t;
    logic [CntW-1:0] cnt_b;
    logic [CntW-1:0] cnt_m;
    logic [CntW-1:0] cnt_t;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_DIV_RAW, ST_PEAK, ST_DIV_NORM, ST_SMOOTH,
    ST_PULSE, ST_ENERGY, ST_DECAY, ST_EMIT
  } eng_state_t;
endpackage
`default_nettype wire

// ----- rtl/sbbt_front.sv -----
// bin accumulator: band sums and bin count, closes frames and turns decay and clear items into commands
`default_nettype none
module sbbt_front (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  input  sbbt_pkg::in_item_t in_item,
  input  wire logic [8:0] bass_end,
  input  wire logic [8:0] mid_end,
  input  wire logic [8:0] treb_end,
  input  wire logic q_full,
  output logic q_push,
  output sbbt_pkg::cmd_t q_cmd
);
  import sbbt_pkg::*;

  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [SumW-1:0] sb_r, sm_r, st_r, sb_nxt, sm_nxt, st_nxt;
  logic take;
  logic in_b, in_m, in_t, room;
  logic [CntW-1:0] n_c, cb, cm, ct;

  function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] s,
                                               input logic [15:0] m);
    logic [SumW:0] t;
    t = {1'b0, s} + {{(SumW-15){1'b0}}, m};
    return t[SumW] ? {SumW{1'b1}} : t[SumW-1:0];
  endfunction

  assign take = in_push && !q_full;
  assign room = cnt_r < CntW'(MaxBins);
  assign in_b = cnt_r < bass_end;
  assign in_m = cnt_r >= bass_end && cnt_r < mid_end;
  assign in_t = cnt_r >= mid_end && cnt_r < treb_end;

  always_comb begin
    sb_nxt = sb_r; sm_nxt = sm_r; st_nxt = st_r; cnt_nxt = cnt_r;
    if (room) begin
      if (in_b) sb_nxt = sat_add(sb_r, in_item.magnitude);
      if (in_m) sm_nxt = sat_add(sm_r, in_item.magnitude);
      if (in_t) st_nxt = sat_add(st_r, in_item.magnitude);
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_comb begin
    n_c = cnt_nxt;
    cb = (bass_end < n_c) ? bass_end : n_c;
    cm = (mid_end < n_c) ? mid_end : n_c;
    ct = (treb_end < n_c) ? treb_end : n_c;
    q_cmd.ft = in_item.frame_time;
    q_cmd.sum_b = sb_nxt;
    q_cmd.sum_m = sm_nxt;
    q_cmd.sum_t = st_nxt;
    q_cmd.cnt_b = cb;
    q_cmd.cnt_m = (cm > cb) ? cm - cb : '0;
    q_cmd.cnt_t = (ct > cm) ? ct - cm : '0;
    q_cmd.kind = CMD_FRAME;
    q_push = 1'b0;
    if (take) begin
      unique case (opcode_t'(in_item.opcode))
        OP_BIN: begin
          q_push = in_item.last_bin;
        end
        OP_DECAY: begin
          q_cmd.kind = CMD_DECAY; q_push = 1'b1;
        end
        OP_CLEAR: begin
          q_cmd.kind = CMD_CLEAR; q_push = 1'b1;
        end
        default: q_push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; sb_r <= '0; sm_r <= '0; st_r <= '0;
    end else if (take) begin
      if (in_item.opcode == OP_BIN && !in_item.last_bin) begin
        cnt_r <= cnt_nxt; sb_r <= sb_nxt; sm_r <= sm_nxt; st_r <= st_nxt;
      end else if (in_item.opcode != OP_NONE) begin
        cnt_r <= '0; sb_r <= '0; sm_r <= '0; st_r <= '0;
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/sbbt_cmd_fifo.sv -----
// small command queue between accumulator and frame engine
`default_nettype none
module sbbt_cmd_fifo (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  sbbt_pkg::cmd_t din,
  output logic full,
  input  wire logic pop,
  output logic empty,
  output sbbt_pkg::cmd_t dout
);
  import sbbt_pkg::*;

  cmd_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign dout = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push && !full) - 2'(pop && !empty);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/sbbt_div.sv -----
// radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one bit a cycle
`default_nettype none
module sbbt_div (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic [31:0] dividend,
  input  wire logic [15:0] divisor,
  output logic busy,
  output logic [31:0] quot
);
  logic [5:0] step_r;
  logic [31:0] q_r;
  logic [16:0] rem_r;
  logic [15:0] d_r;
  logic [17:0] trial;
  logic [16:0] shifted;

  assign busy = step_r != 6'd0;
  assign quot = q_r;
  assign shifted = {rem_r[15:0], q_r[31]};
  assign trial = {1'b0, shifted} - {2'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (start) begin
      step_r <= 6'd32;
    end else if (busy) begin
      step_r <= step_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend; rem_r <= '0; d_r <= divisor;
    end else if (busy) begin
      if (!trial[17]) begin
        rem_r <= trial[16:0]; q_r <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= shifted; q_r <= {q_r[30:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/sbbt_engine.sv -----
// frame engine: per band division, peak, normalization, smoothing, pulse, energy; also decay and clear
`default_nettype none
module sbbt_engine (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_empty,
  input  sbbt_pkg::cmd_t q_cmd,
  output logic q_pop,
  input  wire logic [15:0] thresh,
  output logic out_empty,
  input  wire logic out_pop,
  output sbbt_pkg::out_item_t out_item
);
  import sbbt_pkg::*;

  eng_state_t state_r, state_nxt;
  cmd_t cmd_r;
  logic [1:0] band_r;
  logic started_r;
  logic [15:0] peak_r [3];
  logic [15:0] smooth_r [3];
  logic [15:0] prev_r, pulse_r, energy_r;
  logic [15:0] pfac_r, raw_r, norm_r, norm0_r;
  logic [31:0] acc_r;
  logic out_valid_r;
  out_item_t out_r;

  logic div_start, div_busy;
  logic [31:0] div_dvd, div_q;
  logic [15:0] div_dsr;
  logic [SumW-1:0] cur_sum;
  logic [CntW-1:0] cur_cnt;
  logic [15:0] cur_rate;

  sbbt_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dsr), .busy(div_busy), .quot(div_q)
  );

  always_comb begin
    case (band_r)
      2'd0: begin cur_sum = cmd_r.sum_b; cur_cnt = cmd_r.cnt_b; cur_rate = 16'd10; end
      2'd1: begin cur_sum = cmd_r.sum_m; cur_cnt = cmd_r.cnt_m; cur_rate = 16'd12; end
      default: begin cur_sum = cmd_r.sum_t; cur_cnt = cmd_r.cnt_t; cur_rate = 16'd14; end
    endcase
  end

  assign out_empty = !out_valid_r;
  assign out_item = out_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:
        if (!q_empty && !out_valid_r) begin
          unique case (q_cmd.kind)
            CMD_FRAME: state_nxt = ST_PREP;
            CMD_DECAY: state_nxt = ST_DECAY;
            default: state_nxt = ST_IDLE;
          endcase
        end
      ST_PREP: state_nxt = ST_DIV_RAW;
      ST_DIV_RAW:
        if ((started_r && !div_busy) || (!started_r && cur_cnt == '0))
          state_nxt = ST_PEAK;
      ST_PEAK: state_nxt = ST_DIV_NORM;
      ST_DIV_NORM: if (started_r && !div_busy) state_nxt = ST_SMOOTH;
      ST_SMOOTH: state_nxt = (band_r == 2'd2) ? ST_PULSE : ST_DIV_RAW;
      ST_PULSE: state_nxt = ST_ENERGY;
      ST_ENERGY: state_nxt = ST_EMIT;
      ST_DECAY: state_nxt = ST_EMIT;
      ST_EMIT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop = state_r == ST_IDLE && !q_empty && !out_valid_r;
    div_start = 1'b0;
    div_dvd = {8'd0, cur_sum};
    div_dsr = {7'd0, cur_cnt};
    if (state_r == ST_DIV_RAW && !started_r && cur_cnt != '0) div_start = 1'b1;
    if (state_r == ST_DIV_NORM && !started_r) begin
      div_dvd = {raw_r, 16'd0};
      div_dsr = peak_r[band_r];
      div_start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    logic [31:0] p;
    logic [15:0] dec, cand, k, diff, step, d7;
    logic [16:0] sum17;
    logic [19:0] ft4;
    logic [35:0] e;
    if (!rst_n) begin
      started_r <= 1'b0; out_valid_r <= 1'b0; band_r <= '0;
      for (int i = 0; i < 3; i++) begin
        peak_r[i] <= KPeakReset; smooth_r[i] <= '0;
      end
      prev_r <= '0; pulse_r <= '0; energy_r <= '0;
    end else begin
      if (out_valid_r && out_pop) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          band_r <= '0; started_r <= 1'b0;
          if (q_pop) begin
            cmd_r <= q_cmd;
            if (q_cmd.kind == CMD_CLEAR) begin
              for (int i = 0; i < 3; i++) begin
                peak_r[i] <= KPeakReset; smooth_r[i] <= '0;
              end
              prev_r <= '0; pulse_r <= '0; energy_r <= '0;
            end
          end
        end
        ST_PREP: begin
          p = cmd_r.ft * KPeakDecay;
          pfac_r <= (p[31:16] == 16'd0) ? Full : 16'(17'h10000 - {1'b0, p[31:16]});
          if (p[31:16] == 16'd0) acc_r <= 32'd1;
          else acc_r <= 32'd0;
        end
        ST_DIV_RAW: begin
          if (!started_r) begin
            // an empty band has raw level zero and skips its division
            if (cur_cnt == '0) raw_r <= '0;
            else started_r <= 1'b1;
          end else if (!div_busy) begin
            raw_r <= (div_q[31:16] != 0) ? Full : div_q[15:0];
            started_r <= 1'b0;
          end
        end
        ST_PEAK: begin
          // factor 1.0 (ft*0.3 truncates to zero) keeps peak as is
          p = peak_r[band_r] * pfac_r;
          dec = acc_r[0] ? peak_r[band_r] : p[31:16];
          sum17 = {1'b0, raw_r} + {1'b0, KFloor};
          cand = sum17[16] ? Full : sum17[15:0];
          peak_r[band_r] <= (dec > cand) ? dec : cand;
        end
        ST_DIV_NORM: begin
          if (!started_r) started_r <= 1'b1;
          else if (!div_busy) begin
            norm_r <= (div_q[31:16] != 0) ? Full : div_q[15:0];
            if (band_r == 2'd0) norm0_r <= (div_q[31:16] != 0) ? Full : div_q[15:0];
            started_r <= 1'b0;
          end
        end
        ST_SMOOTH: begin
          p = cmd_r.ft * cur_rate;
          k = 16'hFFFF;
          diff = (norm_r >= smooth_r[band_r]) ? norm_r - smooth_r[band_r]
                                              : smooth_r[band_r] - norm_r;
          if (p >= 32'h10000) step = diff;
          else begin
            k = p[15:0];
            p = diff * k;
            step = p[31:16];
          end
          smooth_r[band_r] <= (norm_r >= smooth_r[band_r]) ? smooth_r[band_r] + step
                                                           : smooth_r[band_r] - step;
          band_r <= band_r + 1'b1;
        end
        ST_PULSE: begin
          dec = pulse_r;
          if (norm0_r > prev_r && (norm0_r - prev_r) > thresh) begin
            diff = norm0_r - prev_r;
            p = {16'd0, diff} * 32'd7;
            d7 = (p[31:1] > 31'hFFFF) ? Full : p[16:1];
            sum17 = {1'b0, pulse_r} + {1'b0, d7};
            dec = sum17[16] ? Full : sum17[15:0];
          end
          ft4 = {2'b0, cmd_r.ft, 2'b0};
          pulse_r <= ({4'd0, dec} > ft4) ? 16'({4'd0, dec} - ft4) : '0;
          prev_r <= norm0_r;
        end
        ST_ENERGY: begin
          e = smooth_r[0] * WBass + smooth_r[1] * WMid + smooth_r[2] * WTreb;
          energy_r <= e[31:16];
        end
        ST_DECAY: begin
          p = cmd_r.ft * 32'd6;
          for (int i = 0; i < 3; i++) begin
            e = smooth_r[i] * (p >= 32'h10000 ? 32'd0 : 32'h10000 - p);
            smooth_r[i] <= e[31:16];
          end
          e = energy_r * (p >= 32'h10000 ? 32'd0 : 32'h10000 - p);
          energy_r <= e[31:16];
          // ft*3.5 reaches 18 bits
          p = {16'd0, cmd_r.ft} * 32'd7;
          pulse_r <= ({2'b0, pulse_r} > p[18:1]) ? 16'({2'b0, pulse_r} - p[18:1]) : '0;
        end
        ST_EMIT: begin
          out_valid_r <= 1'b1;
          out_r.bass_level <= smooth_r[0];
          out_r.mid_level <= smooth_r[1];
          out_r.treble_level <= smooth_r[2];
          out_r.beat_pulse <= pulse_r;
          out_r.energy_level <= energy_r;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/spectrum_band_beat_tracker.sv -----
// top level of the spectral band beat tracker
`default_nettype none
// Spectral band beat tracker. Bins of one frame are pushed one per cycle while
// the command queue is not full and summed into bass, mid and treble
// accumulators at full rate; a bin marked last_bin, a decay item or a clear
// item becomes a command in a two-entry queue. The frame engine works each
// command: per band one 32-step serial division for the raw level and one for
// the normalized level, and a band with no bins skips its raw division. Bins
// keep streaming while the engine works until the command queue fills. One
// result register holds the finished transaction until it is popped.
// Registers are written via cfg_we, cfg_addr, cfg_data and must only change
// while the block is idle.
module spectrum_band_beat_tracker (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  output logic in_full,
  input  sbbt_pkg::in_item_t in_data,
  output logic out_empty,
  input  wire logic out_pop,
  output sbbt_pkg::out_item_t out_data,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_addr,
  input  wire logic [15:0] cfg_data
);
  import sbbt_pkg::*;

  logic [8:0] bass_end_r, mid_end_r, treb_end_r;
  logic [15:0] thresh_r;
  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_din, q_dout;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bass_end_r <= 9'd8; mid_end_r <= 9'd48; treb_end_r <= 9'd128;
      thresh_r <= 16'd5243;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        RegBassEnd: bass_end_r <= cfg_data[8:0];
        RegMidEnd: mid_end_r <= cfg_data[8:0];
        RegTrebEnd: treb_end_r <= cfg_data[8:0];
        RegThresh: thresh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // the front stalls only when the command queue is full
  assign in_full = q_full;

  sbbt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_item(in_data),
    .bass_end(bass_end_r), .mid_end(mid_end_r), .treb_end(treb_end_r),
    .q_full(q_full), .q_push(q_push), .q_cmd(q_din)
  );

  sbbt_cmd_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .din(q_din), .full(q_full),
    .pop(q_pop), .empty(q_empty), .dout(q_dout)
  );

  sbbt_engine u_engine (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_cmd(q_dout), .q_pop(q_pop),
    .thresh(thresh_r), .out_empty(out_empty), .out_pop(out_pop),
    .out_item(out_data)
  );
endmodule
`default_nettype wire
